// ===== hdl/tap_pkg.sv =====
// tap_pkg: shared types and constants for the triangle attribute plane setup block
// no dependencies; used by the top level

package tap_pkg;

    localparam int OUT_W      = 48;   // width of every result field
    localparam int THRESH_W   = 32;   // width of the degenerate threshold register
    localparam int GRAD_SHIFT = 14;   // gradient numerator scale to reach Q.14
    localparam int OFS_SHIFT  = 10;   // offset numerator scale to reach Q.10
    localparam int MEAN_DIV   = 3;    // divisor of the mean fallback

    // register index decode (one word per register)
    localparam logic REG_THRESHOLD = 1'b0;

    // per-item flags that travel beside the divider chain
    typedef struct packed {
        logic valid;
        logic degen;
        logic neg_x;
        logic neg_y;
        logic neg_c;
    } t_side;

endpackage

// ===== hdl/tap_div_cell.sv =====
// tap_div_cell: one restoring division step, one quotient bit per cell
// no dependencies; instantiated by tap_div_chain

module tap_div_cell #(
    parameter int NW  = 64,
    parameter int DMW = 35
) (
    input  logic           i_clk,
    input  logic [NW-1:0]  i_num,
    input  logic [NW-1:0]  i_quo,
    input  logic [DMW-1:0] i_rem,
    input  logic [DMW-1:0] i_div,
    output logic [NW-1:0]  o_num,
    output logic [NW-1:0]  o_quo,
    output logic [DMW-1:0] o_rem,
    output logic [DMW-1:0] o_div
);

    logic [NW-1:0]  r_num, r_quo;
    logic [DMW-1:0] r_rem, r_div;
    logic [DMW:0]   trial, diff;
    logic           ge;

    // bring down the next dividend bit and try a subtract
    assign trial = {i_rem, i_num[NW-1]};
    assign diff  = trial - {1'b0, i_div};
    assign ge    = (trial >= {1'b0, i_div});

    always_ff @(posedge i_clk) begin
        r_num <= {i_num[NW-2:0], 1'b0};
        r_quo <= {i_quo[NW-2:0], ge};
        r_rem <= ge ? diff[DMW-1:0] : trial[DMW-1:0];
        r_div <= i_div;
    end

    assign o_num = r_num;
    assign o_quo = r_quo;
    assign o_rem = r_rem;
    assign o_div = r_div;

endmodule

// ===== hdl/tap_div_chain.sv =====
// tap_div_chain: row of NW division cells, one new dividend each cycle
// depends on tap_div_cell

module tap_div_chain #(
    parameter int NW  = 64,
    parameter int DMW = 35
) (
    input  logic           i_clk,
    input  logic [NW-1:0]  i_num,
    input  logic [DMW-1:0] i_div,
    output logic [NW-1:0]  o_quo,
    output logic [DMW-1:0] o_rem,
    output logic [DMW-1:0] o_div
);

    logic [NW-1:0]  num [NW+1];
    logic [NW-1:0]  quo [NW+1];
    logic [DMW-1:0] rem [NW+1];
    logic [DMW-1:0] dvs [NW+1];

    assign num[0] = i_num;
    assign quo[0] = '0;
    assign rem[0] = '0;
    assign dvs[0] = i_div;

    for (genvar g = 0; g < NW; g++) begin : g_cell
        tap_div_cell #(
            .NW  (NW),
            .DMW (DMW)
        ) u_cell (
            .i_clk (i_clk),
            .i_num (num[g]),
            .i_quo (quo[g]),
            .i_rem (rem[g]),
            .i_div (dvs[g]),
            .o_num (num[g+1]),
            .o_quo (quo[g+1]),
            .o_rem (rem[g+1]),
            .o_div (dvs[g+1])
        );
    end

    assign o_quo = quo[NW];
    assign o_rem = rem[NW];
    assign o_div = dvs[NW];

endmodule

// ===== hdl/triangle_attribute_plane_setup.sv =====
// triangle_attribute_plane_setup: plane equation setup for one triangle attribute
// depends on tap_pkg and tap_div_chain
//
// usage:
//   input: drive the vertex and value ports with start high; the transfer is taken
//   on any edge where start is high and busy is low. busy is always low, so one
//   triangle can be taken every cycle.
//   output: each result shows for one cycle with o_valid high; the receiver cannot
//   stall, so results must be taken when they appear.
//   divider: the bit-per-cell divider chains take CNW-bit dividends, where
//   CNW = max(VALUE_WIDTH+2*COORD_WIDTH+3, VALUE_WIDTH+2*COORD_WIDTH+4) + 12.
//   throughput: one triangle per cycle. config: degenerate_threshold at byte
//   address 0 over the apb port; the user must write it only while no triangle
//   is in flight, and the block itself does not enforce this. pready is always
//   high.
//   reset: synchronous active low; clears the in-flight marks and the threshold.
//   degenerate triangles reuse the divider with a divisor of three for the mean.

module triangle_attribute_plane_setup #(
    parameter int COORD_WIDTH = 16,
    parameter int VALUE_WIDTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [COORD_WIDTH-1:0]              i_vertex0_x,
    input  logic [COORD_WIDTH-1:0]              i_vertex0_y,
    input  logic [COORD_WIDTH-1:0]              i_vertex1_x,
    input  logic [COORD_WIDTH-1:0]              i_vertex1_y,
    input  logic [COORD_WIDTH-1:0]              i_vertex2_x,
    input  logic [COORD_WIDTH-1:0]              i_vertex2_y,
    input  logic signed [VALUE_WIDTH-1:0]       i_value0,
    input  logic signed [VALUE_WIDTH-1:0]       i_value1,
    input  logic signed [VALUE_WIDTH-1:0]       i_value2,
    output logic                                o_valid,
    output logic signed [tap_pkg::OUT_W-1:0]    o_gradient_x,
    output logic signed [tap_pkg::OUT_W-1:0]    o_gradient_y,
    output logic signed [tap_pkg::OUT_W-1:0]    o_plane_offset,
    output logic                                o_degenerate,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [tap_pkg::THRESH_W-1:0]        pwdata,
    output logic [tap_pkg::THRESH_W-1:0]        prdata,
    output logic                                pready
);

    localparam int CW   = COORD_WIDTH;
    localparam int VW   = VALUE_WIDTH;
    localparam int DW   = CW + 1;
    localparam int ZW   = VW + 1;
    localparam int DETW = 2 * DW + 1;
    localparam int NUMW = DW + ZW + 1;
    localparam int AW   = VW + DETW;
    localparam int BW   = NUMW + CW + 1;
    localparam int CSW  = ((AW > BW) ? AW : BW) + 2;
    localparam int CNW  = CSW + tap_pkg::OFS_SHIFT;
    localparam int SW   = VW + 2;
    localparam int CMPW = (DETW > tap_pkg::THRESH_W) ? DETW : tap_pkg::THRESH_W;
    localparam int OW   = tap_pkg::OUT_W;
    localparam int LATENCY = 8 + CNW;

    localparam logic [CNW:0] POS_MAX = (CNW+1)'((64'd1 << (OW - 1)) - 64'd1);
    localparam logic [CNW:0] NEG_MAG = (CNW+1)'(64'd1 << (OW - 1));

    // ---------------- config port ----------------
    logic [tap_pkg::THRESH_W-1:0] r_threshold;
    logic                         cfg_wr;

    assign cfg_wr = psel && penable && pwrite && (paddr[2] == tap_pkg::REG_THRESHOLD);
    assign pready = 1'b1;
    assign prdata = (paddr[2] == tap_pkg::REG_THRESHOLD) ? r_threshold : '0;
    assign busy   = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= '0;
        end else if (cfg_wr) begin
            r_threshold <= pwdata;
        end
    end

    // ---------------- stage 1: differences ----------------
    logic                 r_v1;
    logic signed [DW-1:0] r_dx10, r_dy10, r_dx20, r_dy20;
    logic signed [ZW-1:0] r_dz10, r_dz20;
    logic signed [SW-1:0] r_sum1;
    logic [CW-1:0]        r_x0_1, r_y0_1;
    logic signed [VW-1:0] r_v0_1;

    always_ff @(posedge i_clk) begin
        r_dx10 <= $signed({1'b0, i_vertex1_x}) - $signed({1'b0, i_vertex0_x});
        r_dy10 <= $signed({1'b0, i_vertex1_y}) - $signed({1'b0, i_vertex0_y});
        r_dx20 <= $signed({1'b0, i_vertex2_x}) - $signed({1'b0, i_vertex0_x});
        r_dy20 <= $signed({1'b0, i_vertex2_y}) - $signed({1'b0, i_vertex0_y});
        r_dz10 <= $signed({i_value1[VW-1], i_value1}) - $signed({i_value0[VW-1], i_value0});
        r_dz20 <= $signed({i_value2[VW-1], i_value2}) - $signed({i_value0[VW-1], i_value0});
        r_sum1 <= SW'(i_value0) + SW'(i_value1) + SW'(i_value2);
        r_x0_1 <= i_vertex0_x;
        r_y0_1 <= i_vertex0_y;
        r_v0_1 <= i_value0;
    end

    // ---------------- stage 2: cross products ----------------
    logic                        r_v2;
    logic signed [2*DW-1:0]      r_p1, r_p2;
    logic signed [DW+ZW-1:0]     r_p3, r_p4, r_p5, r_p6;
    logic signed [SW-1:0]        r_sum2;
    logic [CW-1:0]               r_x0_2, r_y0_2;
    logic signed [VW-1:0]        r_v0_2;

    always_ff @(posedge i_clk) begin
        r_p1   <= r_dx10 * r_dy20;
        r_p2   <= r_dy10 * r_dx20;
        r_p3   <= r_dz10 * r_dy20;
        r_p4   <= r_dy10 * r_dz20;
        r_p5   <= r_dx10 * r_dz20;
        r_p6   <= r_dz10 * r_dx20;
        r_sum2 <= r_sum1;
        r_x0_2 <= r_x0_1;
        r_y0_2 <= r_y0_1;
        r_v0_2 <= r_v0_1;
    end

    // ---------------- stage 3: determinant and numerators ----------------
    logic                   r_v3;
    logic signed [DETW-1:0] r_det3;
    logic signed [NUMW-1:0] r_numx3, r_numy3;
    logic signed [SW-1:0]   r_sum3;
    logic [CW-1:0]          r_x0_3, r_y0_3;
    logic signed [VW-1:0]   r_v0_3;

    always_ff @(posedge i_clk) begin
        r_det3  <= DETW'(r_p1) - DETW'(r_p2);
        r_numx3 <= NUMW'(r_p3) - NUMW'(r_p4);
        r_numy3 <= NUMW'(r_p5) - NUMW'(r_p6);
        r_sum3  <= r_sum2;
        r_x0_3  <= r_x0_2;
        r_y0_3  <= r_y0_2;
        r_v0_3  <= r_v0_2;
    end

    // ---------------- stage 4: offset products, magnitudes, threshold ----------------
    logic                   r_v4;
    logic signed [AW-1:0]   r_a4;
    logic signed [BW-1:0]   r_b4, r_c4;
    logic [DETW-1:0]        r_dmag4, det_mag;
    logic [NUMW-1:0]        r_nxmag4, r_nymag4;
    logic                   r_dneg4, r_nxneg4, r_nyneg4, r_deg4;
    logic signed [SW-1:0]   r_sum4;

    assign det_mag = r_det3[DETW-1] ? DETW'(-r_det3) : DETW'(r_det3);

    always_ff @(posedge i_clk) begin
        r_a4     <= r_v0_3 * r_det3;
        r_b4     <= r_numx3 * $signed({1'b0, r_x0_3});
        r_c4     <= r_numy3 * $signed({1'b0, r_y0_3});
        r_dmag4  <= det_mag;
        r_nxmag4 <= r_numx3[NUMW-1] ? NUMW'(-r_numx3) : NUMW'(r_numx3);
        r_nymag4 <= r_numy3[NUMW-1] ? NUMW'(-r_numy3) : NUMW'(r_numy3);
        r_dneg4  <= r_det3[DETW-1];
        r_nxneg4 <= r_numx3[NUMW-1];
        r_nyneg4 <= r_numy3[NUMW-1];
        r_deg4   <= (CMPW'(det_mag) <= CMPW'(r_threshold));
        r_sum4   <= r_sum3;
    end

    // ---------------- stage 5: offset numerator ----------------
    logic                  r_v5;
    logic signed [CSW-1:0] r_cn5;
    logic [DETW-1:0]       r_dmag5;
    logic [NUMW-1:0]       r_nxmag5, r_nymag5;
    logic                  r_dneg5, r_nxneg5, r_nyneg5, r_deg5;
    logic signed [SW-1:0]  r_sum5;

    always_ff @(posedge i_clk) begin
        r_cn5    <= CSW'(r_a4) - CSW'(r_b4) - CSW'(r_c4);
        r_dmag5  <= r_dmag4;
        r_nxmag5 <= r_nxmag4;
        r_nymag5 <= r_nymag4;
        r_dneg5  <= r_dneg4;
        r_nxneg5 <= r_nxneg4;
        r_nyneg5 <= r_nyneg4;
        r_deg5   <= r_deg4;
        r_sum5   <= r_sum4;
    end

    // ---------------- stage 6: dividend select ----------------
    logic [CNW-1:0]   r_nx6, r_ny6, r_nc6;
    logic [DETW-1:0]  r_dv6;
    tap_pkg::t_side   r_side6;
    logic [CSW-1:0]   cn_mag;
    logic [SW-1:0]    sum_mag;

    assign cn_mag  = r_cn5[CSW-1] ? CSW'(-r_cn5) : CSW'(r_cn5);
    assign sum_mag = r_sum5[SW-1] ? SW'(-r_sum5) : SW'(r_sum5);

    always_ff @(posedge i_clk) begin
        if (r_deg5) begin
            // mean fallback: (v0+v1+v2)*1024 / 3
            r_nx6 <= '0;
            r_ny6 <= '0;
            r_nc6 <= CNW'(sum_mag) << tap_pkg::OFS_SHIFT;
            r_dv6 <= DETW'(tap_pkg::MEAN_DIV);
        end else begin
            r_nx6 <= CNW'(r_nxmag5) << tap_pkg::GRAD_SHIFT;
            r_ny6 <= CNW'(r_nymag5) << tap_pkg::GRAD_SHIFT;
            r_nc6 <= CNW'(cn_mag) << tap_pkg::OFS_SHIFT;
            r_dv6 <= r_dmag5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side6 <= '0;
        end else begin
            r_side6.valid <= r_v5;
            r_side6.degen <= r_deg5;
            r_side6.neg_x <= !r_deg5 && (r_nxneg5 != r_dneg5);
            r_side6.neg_y <= !r_deg5 && (r_nyneg5 != r_dneg5);
            r_side6.neg_c <= r_deg5 ? r_sum5[SW-1] : (r_cn5[CSW-1] != r_dneg5);
        end
    end

    // valid marks for the front stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1          <= 1'b0;
            r_v2          <= 1'b0;
            r_v3          <= 1'b0;
            r_v4          <= 1'b0;
            r_v5          <= 1'b0;
        end else begin
            r_v1          <= start && !busy;
            r_v2          <= r_v1;
            r_v3          <= r_v2;
            r_v4          <= r_v3;
            r_v5          <= r_v4;
        end
    end

    // ---------------- divider chains ----------------
    logic [CNW-1:0]  qx, qy, qc;
    logic [DETW-1:0] rx, ry, rc, dx, dy, dc;

    tap_div_chain #(.NW(CNW), .DMW(DETW)) u_div_x (
        .i_clk (i_clk), .i_num (r_nx6), .i_div (r_dv6),
        .o_quo (qx), .o_rem (rx), .o_div (dx)
    );

    tap_div_chain #(.NW(CNW), .DMW(DETW)) u_div_y (
        .i_clk (i_clk), .i_num (r_ny6), .i_div (r_dv6),
        .o_quo (qy), .o_rem (ry), .o_div (dy)
    );

    tap_div_chain #(.NW(CNW), .DMW(DETW)) u_div_c (
        .i_clk (i_clk), .i_num (r_nc6), .i_div (r_dv6),
        .o_quo (qc), .o_rem (rc), .o_div (dc)
    );

    // flags ride a shift line beside the chain
    tap_pkg::t_side r_side [CNW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CNW; i++) begin
                r_side[i] <= '0;
            end
        end else begin
            r_side[0] <= r_side6;
            for (int i = 1; i < CNW; i++) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    // ---------------- rounding ----------------
    logic [CNW:0]   r_mx, r_my, r_mc;
    tap_pkg::t_side r_side_r;

    always_ff @(posedge i_clk) begin
        r_mx <= {1'b0, qx} + (CNW+1)'({rx, 1'b0} >= {1'b0, dx});
        r_my <= {1'b0, qy} + (CNW+1)'({ry, 1'b0} >= {1'b0, dy});
        r_mc <= {1'b0, qc} + (CNW+1)'({rc, 1'b0} >= {1'b0, dc});
        if (!i_rst_n) begin
            r_side_r <= '0;
        end else begin
            r_side_r <= r_side[CNW-1];
        end
    end

    // ---------------- saturation and output register ----------------
    function automatic logic [OW-1:0] sat_out(input logic neg, input logic [CNW:0] mag);
        logic [OW-1:0] m;
        m = mag[OW-1:0];
        if (neg) begin
            if (mag > NEG_MAG) begin
                m = NEG_MAG[OW-1:0];
            end
            sat_out = OW'(-m);
        end else begin
            if (mag > POS_MAX) begin
                m = POS_MAX[OW-1:0];
            end
            sat_out = m;
        end
    endfunction

    logic                 r_valid, r_degenerate;
    logic signed [OW-1:0] r_gx, r_gy, r_pc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_side_r.valid;
        end
        r_gx         <= $signed(sat_out(r_side_r.neg_x, r_mx));
        r_gy         <= $signed(sat_out(r_side_r.neg_y, r_my));
        r_pc         <= $signed(sat_out(r_side_r.neg_c, r_mc));
        r_degenerate <= r_side_r.degen;
    end

    assign o_valid        = r_valid;
    assign o_gradient_x   = r_gx;
    assign o_gradient_y   = r_gy;
    assign o_plane_offset = r_pc;
    assign o_degenerate   = r_degenerate;

`ifndef SYNTHESIS
    a_result_has_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LATENCY))
        else $error("result without a start transfer");

    a_degen_flat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_degenerate) |-> (o_gradient_x == 0 && o_gradient_y == 0))
        else $error("degenerate result with nonzero gradient");

    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr |=> (r_threshold == $past(pwdata)))
        else $error("threshold write lost");

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");
`endif

endmodule

// ===== bench/triangle_attribute_plane_setup_tb.sv =====
// triangle_attribute_plane_setup_tb: self-checking bench for the plane setup block
// depends on tap_pkg and the triangle_attribute_plane_setup rtl
`timescale 1ns / 1ps

module triangle_attribute_plane_setup_tb;

    typedef struct packed {
        logic [15:0] x0, y0, x1, y1, x2, y2;
        logic signed [15:0] v0, v1, v2;
    } t_tri;

    typedef struct packed {
        logic signed [tap_pkg::OUT_W-1:0] gx;
        logic signed [tap_pkg::OUT_W-1:0] gy;
        logic signed [tap_pkg::OUT_W-1:0] ofs;
        logic                             degen;
    } t_plane;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_tri tri_in = '0;
    logic o_valid;
    logic signed [tap_pkg::OUT_W-1:0] o_gradient_x, o_gradient_y, o_plane_offset;
    logic o_degenerate;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [tap_pkg::THRESH_W-1:0] pwdata = '0;
    logic [tap_pkg::THRESH_W-1:0] prdata;
    logic pready;

    t_plane planes_due[$];
    logic [tap_pkg::THRESH_W-1:0] thresh_model = '0;
    int errors = 0;
    int triangles_sent = 0;
    int planes_seen = 0;
    int degen_seen = 0;
    int idle_pct = 37;

    always #1 i_clk = ~i_clk;

    triangle_attribute_plane_setup DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_vertex0_x(tri_in.x0), .i_vertex0_y(tri_in.y0),
        .i_vertex1_x(tri_in.x1), .i_vertex1_y(tri_in.y1),
        .i_vertex2_x(tri_in.x2), .i_vertex2_y(tri_in.y2),
        .i_value0(tri_in.v0), .i_value1(tri_in.v1), .i_value2(tri_in.v2),
        .o_valid(o_valid), .o_gradient_x(o_gradient_x), .o_gradient_y(o_gradient_y),
        .o_plane_offset(o_plane_offset), .o_degenerate(o_degenerate),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // quotient of magnitudes, ties away from zero
    function automatic logic [127:0] round_quot(logic [127:0] n, logic [127:0] d);
        logic [127:0] q, r;
        q = n / d;
        r = n % d;
        if (2 * r >= d) q = q + 1;
        return q;
    endfunction

    function automatic logic signed [tap_pkg::OUT_W-1:0] clamp48(bit neg, logic [127:0] mag);
        logic [127:0] lim;
        lim = neg ? (128'd1 << 47) : ((128'd1 << 47) - 1);
        if (mag > lim) mag = lim;
        return neg ? -mag[tap_pkg::OUT_W-1:0] : mag[tap_pkg::OUT_W-1:0];
    endfunction

    function automatic logic [127:0] mag128(logic signed [127:0] a);
        return a < 0 ? -a : a;
    endfunction

    function automatic t_plane plane_through(t_tri t, logic [tap_pkg::THRESH_W-1:0] thr);
        logic signed [127:0] x0, y0, dx10, dy10, dx20, dy20, v0, dz10, dz20;
        logic signed [127:0] det, numx, numy, sum, cn;
        t_plane p;
        x0 = 128'(t.x0); y0 = 128'(t.y0);
        v0 = 128'(t.v0);
        dx10 = 128'($signed({1'b0, t.x1}) - $signed({1'b0, t.x0}));
        dy10 = 128'($signed({1'b0, t.y1}) - $signed({1'b0, t.y0}));
        dx20 = 128'($signed({1'b0, t.x2}) - $signed({1'b0, t.x0}));
        dy20 = 128'($signed({1'b0, t.y2}) - $signed({1'b0, t.y0}));
        dz10 = 128'(t.v1) - 128'(t.v0);
        dz20 = 128'(t.v2) - 128'(t.v0);
        det = dx10 * dy20 - dy10 * dx20;
        if (mag128(det) <= 128'(thr)) begin
            sum = (v0 + 128'(t.v1) + 128'(t.v2)) * 1024;
            p.gx = '0;
            p.gy = '0;
            p.ofs = clamp48(sum < 0, round_quot(mag128(sum), tap_pkg::MEAN_DIV));
            p.degen = 1'b1;
            return p;
        end
        numx = dz10 * dy20 - dy10 * dz20;
        numy = dx10 * dz20 - dz10 * dx20;
        p.gx = clamp48((numx < 0) != (det < 0),
                       round_quot(mag128(numx) << tap_pkg::GRAD_SHIFT, mag128(det)));
        p.gy = clamp48((numy < 0) != (det < 0),
                       round_quot(mag128(numy) << tap_pkg::GRAD_SHIFT, mag128(det)));
        // offset from exact gradients: (v0*det - numx*x0 - numy*y0) / det
        cn = v0 * 1024 * det - numx * 1024 * x0 - numy * 1024 * y0;
        p.ofs = clamp48((cn < 0) != (det < 0), round_quot(mag128(cn), mag128(det)));
        p.degen = 1'b0;
        return p;
    endfunction

    task automatic send_triangle(t_tri t);
        // idle cycles before the transfer, one coin toss per cycle
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        tri_in <= t;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        planes_due = {planes_due, plane_through(t, thresh_model)};
        triangles_sent++;
    endtask

    task automatic drain_pipe();
        start <= 1'b0;
        while (planes_due.size() != 0) @(posedge i_clk);
        repeat (90) @(posedge i_clk);
    endtask

    task automatic set_threshold(logic [tap_pkg::THRESH_W-1:0] thr);
        drain_pipe();
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 3'(tap_pkg::REG_THRESHOLD) << 2; pwdata <= thr;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        thresh_model = thr;
        pwrite <= 1'b0; penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== thr) begin
            $display("%0t threshold readback: expected %h actual %h", $time, thr, prdata);
            errors++;
        end
        psel <= 1'b0; penable <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_tri mk_tri(int x0, int y0, int x1, int y1, int x2, int y2,
                                    int v0, int v1, int v2);
        t_tri t;
        t.x0 = 16'(x0); t.y0 = 16'(y0); t.x1 = 16'(x1); t.y1 = 16'(y1);
        t.x2 = 16'(x2); t.y2 = 16'(y2);
        t.v0 = 16'(v0); t.v1 = 16'(v1); t.v2 = 16'(v2);
        return t;
    endfunction

    function automatic logic [15:0] near(logic [15:0] base, int spread);
        int c;
        c = int'(base) + $urandom_range(2 * spread) - spread;
        if (c < 0) c = 0;
        if (c > 65535) c = 65535;
        return 16'(c);
    endfunction

    function automatic t_tri random_tri();
        t_tri t;
        int mode, spread;
        t = 144'({$urandom, $urandom, $urandom, $urandom, $urandom});
        mode = $urandom_range(9);
        if (mode < 4) begin
            // small triangle: tiny determinants, steep gradients
            spread = (mode == 0) ? 2 : (mode == 1 ? 16 : 300);
            t.x1 = near(t.x0, spread); t.y1 = near(t.y0, spread);
            t.x2 = near(t.x0, spread); t.y2 = near(t.y0, spread);
        end else if (mode == 4) begin
            // collinear points
            t.x1 = near(t.x0, 200);
            t.y1 = near(t.y0, 200);
            t.x2 = 16'(t.x0 + 2 * (t.x1 - t.x0));
            t.y2 = 16'(t.y0 + 2 * (t.y1 - t.y0));
        end else if (mode == 5) begin
            t.v0 = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            t.v1 = -t.v0;
        end
        return t;
    endfunction

    task automatic test_directed();
        send_triangle(mk_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_triangle(mk_tri(100, 100, 100, 100, 100, 100, 32767, 32767, 32767));
        send_triangle(mk_tri(0, 0, 0, 0, 0, 0, -32768, -32768, -32768));
        send_triangle(mk_tri(0, 0, 0, 0, 0, 0, 1, 0, 0));
        send_triangle(mk_tri(0, 0, 0, 0, 0, 0, -1, 0, 0));
        send_triangle(mk_tri(0, 0, 65535, 0, 0, 65535, 16384, -16384, 0));
        send_triangle(mk_tri(65535, 65535, 0, 65535, 65535, 0, 32767, -32768, 32767));
        send_triangle(mk_tri(0, 0, 65535, 0, 0, 65535, -32768, 32767, -32768));
        send_triangle(mk_tri(0, 65535, 65535, 0, 65535, 65535, 0, 32767, -32768));
        // unit determinant with full swing values: steep gradients
        send_triangle(mk_tri(65535, 65535, 65534, 65535, 65535, 65534, -32768, 32767, 32767));
        send_triangle(mk_tri(0, 0, 1, 0, 0, 1, 32767, -32768, -32768));
        send_triangle(mk_tri(65535, 0, 65534, 0, 65535, 1, 32767, -32768, 32767));
        send_triangle(mk_tri(10, 10, 20, 20, 30, 30, 100, 200, 300));
        send_triangle(mk_tri(0, 0, 3, 0, 0, 3, 1, 2, 2));
        send_triangle(mk_tri(0, 0, 3, 0, 0, 3, -1, -2, -2));
        send_triangle(mk_tri(1000, 2000, 1010, 2000, 1000, 2010, 5, -5, 5));
        send_triangle(mk_tri(0, 0, 16, 0, 0, 16, 16384, 16384, 16384));
    endtask

    task automatic test_random(int count);
        repeat (count) send_triangle(random_tri());
    endtask

    always @(posedge i_clk) begin
        t_plane want;
        if (i_rst_n && o_valid) begin
            planes_seen++;
            if (o_degenerate) degen_seen++;
            if (planes_due.size() == 0) begin
                $display("%0t plane transfer with nothing pending", $time);
                errors++;
            end else begin
                want = planes_due.pop_front();
                if (o_gradient_x !== want.gx) begin
                    $display("%0t gradient_x: expected %0d actual %0d",
                             $time, want.gx, o_gradient_x);
                    errors++;
                end
                if (o_gradient_y !== want.gy) begin
                    $display("%0t gradient_y: expected %0d actual %0d",
                             $time, want.gy, o_gradient_y);
                    errors++;
                end
                if (o_plane_offset !== want.ofs) begin
                    $display("%0t plane_offset: expected %0d actual %0d",
                             $time, want.ofs, o_plane_offset);
                    errors++;
                end
                if (o_degenerate !== want.degen) begin
                    $display("%0t degenerate: expected %0b actual %0b",
                             $time, want.degen, o_degenerate);
                    errors++;
                end
            end
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        set_threshold(32'd300);
        test_directed();
        set_threshold(32'hFFFF_FFFF);
        test_random(60);
        set_threshold(32'd0);
        idle_pct = 0;
        test_random(300);
        idle_pct = 37;
        test_random(300);
        set_threshold(32'd64);
        test_random(200);
        set_threshold($urandom_range(32'h7FFF_FFFF, 32'hFFFF_FFFE));
        test_random(40);
        set_threshold($urandom);
        test_random(60);
        set_threshold($urandom_range(4096));
        test_random(100);
        drain_pipe();
        $display("sent %0d triangles over seven threshold settings, %0d planes checked",
                 triangles_sent, planes_seen);
        $display("%0d degenerate fallbacks, %0d mismatches", degen_seen, errors);
        if (errors == 0 && planes_due.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout with %0d planes pending", planes_due.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/tap_pkg.sv
hdl/tap_div_cell.sv
hdl/tap_div_chain.sv
hdl/triangle_attribute_plane_setup.sv
bench/triangle_attribute_plane_setup_tb.sv
